/* sv/tile_bitplane_to_chunky_unit_macros.svh */
// assertion macros used by the checker file of the bitplane to chunky unit
// each macro expects clk and rst_n to exist in the scope where it is used
`ifndef TILE_BITPLANE_TO_CHUNKY_UNIT_MACROS_SVH
`define TILE_BITPLANE_TO_CHUNKY_UNIT_MACROS_SVH

// same-cycle implication
`define TBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/tbc_pkg.sv */
// shared types, constants and helpers of the bitplane to chunky unit
// no dependencies
`timescale 1ns / 1ps

package tbc_pkg;

    localparam int LANES      = 8;
    localparam int PLANES     = 8;
    localparam int PIX_W      = 8;
    localparam int FIRST_W    = 64;
    localparam int SECOND_W   = 32;
    localparam int ROWS       = 8;
    localparam int ROW_CNT_W  = $clog2(ROWS);
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int CFG_W      = 2;

    // register index, taken from paddr[2]
    typedef enum logic
    {
        REG_DEPTH_MODE   = 1'b0,
        REG_HIRES_SELECT = 1'b1
    } reg_idx_t;

    // depth codes
    localparam logic [CFG_W-1:0] DEPTH_2BPP = 2'd0;
    localparam logic [CFG_W-1:0] DEPTH_4BPP = 2'd1;

    // hires select codes
    localparam logic [CFG_W-1:0] HIRES_ODD  = 2'd1;
    localparam logic [CFG_W-1:0] HIRES_EVEN = 2'd2;

    localparam logic [CFG_W-1:0] DEPTH_RESET = DEPTH_4BPP;
    localparam logic [CFG_W-1:0] HIRES_RESET = 2'd0;

    typedef struct packed
    {
        logic [SECOND_W-1:0] plane_bytes_second;
        logic [FIRST_W-1:0]  plane_bytes_first;
    } in_t;

    typedef struct packed
    {
        logic                   tile_nonblank;
        logic                   last_row;
        logic [LANES*PIX_W-1:0] pixels;
    } out_t;

    // control shared by all lanes for one request
    typedef struct packed
    {
        logic [PLANES-1:0] plane_mask;
        logic              hires;
        logic              odd;
    } lane_ctrl_t;

    function automatic logic [PLANES-1:0] depth_plane_mask(input logic [CFG_W-1:0] depth);
        logic [PLANES-1:0] mask;
        unique case (depth)
            DEPTH_2BPP: mask = 8'h03;
            DEPTH_4BPP: mask = 8'h0f;
            default:    mask = 8'hff;
        endcase
        return mask;
    endfunction

endpackage

/* sv/tbc_lane.sv */
// one pixel lane: gathers a pixel's bit from each plane byte into a colour index
// depends on tbc_pkg
`timescale 1ns / 1ps

module tbc_lane
(
    input  logic [tbc_pkg::FIRST_W-1:0] planes,
    input  logic [2:0]                  pos,
    input  logic [tbc_pkg::PLANES-1:0]  plane_mask,
    output logic [tbc_pkg::PIX_W-1:0]   idx
);

    always_comb
    begin
        logic [7:0] pb;
        idx = '0;
        for (int p = 0; p < tbc_pkg::PLANES; p++)
        begin
            pb = planes[p*8 +: 8];
            // pixel 0 sits in the msb of each plane byte
            idx[p] = pb[3'd7 - pos] & plane_mask[p];
        end
    end

endmodule

/* sv/tbc_merge.sv */
// merging stage: combines lane indices, tracks rows and blank flag, holds the result
// depends on tbc_pkg
`timescale 1ns / 1ps

module tbc_merge
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    input  logic [tbc_pkg::LANES*tbc_pkg::PIX_W-1:0] lane_pixels,
    input  logic                                  chunk_stall,
    output logic                                  chunk_valid,
    output tbc_pkg::out_t                         chunk_row
);

    logic [tbc_pkg::ROW_CNT_W-1:0] row_count_reg, row_count_next;
    logic                          seen_nonzero_reg, seen_nonzero_next;
    logic                          valid_reg, valid_next;
    tbc_pkg::out_t                 data_reg, data_next;
    logic                          nonzero;
    logic                          last;

    assign nonzero = |lane_pixels;
    assign last    = (row_count_reg == tbc_pkg::ROW_CNT_W'(tbc_pkg::ROWS - 1));

    always_comb
    begin
        row_count_next    = row_count_reg;
        seen_nonzero_next = seen_nonzero_reg;
        data_next         = data_reg;
        valid_next        = valid_reg & chunk_stall;
        if (accept)
        begin
            valid_next              = 1'b1;
            data_next.pixels        = lane_pixels;
            data_next.last_row      = last;
            data_next.tile_nonblank = last & (seen_nonzero_reg | nonzero);
            if (last)
            begin
                row_count_next    = '0;
                seen_nonzero_next = 1'b0;
            end
            else
            begin
                row_count_next    = row_count_reg + 1'b1;
                seen_nonzero_next = seen_nonzero_reg | nonzero;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= '0;
            seen_nonzero_reg <= 1'b0;
            valid_reg        <= 1'b0;
        end
        else
        begin
            row_count_reg    <= row_count_next;
            seen_nonzero_reg <= seen_nonzero_next;
            valid_reg        <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign chunk_valid = valid_reg;
    assign chunk_row   = data_reg;

endmodule

/* sv/tile_bitplane_to_chunky_unit.sv */
// an accepted request's result is written into the output register in the next cycle
// throughput: one request per cycle while the output is not stalled; eight pixel lanes work in parallel on each row
// a new request is taken whenever the output register is empty or being drained
// reset: asynchronous active low; clears row count, blank flag and output valid,
//   sets depth to four bpp and hires off
// top level of the bitplane to chunky unit; depends on tbc_pkg, tbc_lane, tbc_merge
`timescale 1ns / 1ps

module tile_bitplane_to_chunky_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tile_valid,
    output logic                          tile_stall,
    input  tbc_pkg::in_t                  tile_row,
    output logic                          chunk_valid,
    input  logic                          chunk_stall,
    output tbc_pkg::out_t                 chunk_row,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tbc_pkg::PADDR_W-1:0]   paddr,
    input  logic [tbc_pkg::PDATA_W-1:0]   pwdata,
    output logic [tbc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [tbc_pkg::CFG_W-1:0] depth_mode_reg, depth_mode_next;
    logic [tbc_pkg::CFG_W-1:0] hires_select_reg, hires_select_next;
    tbc_pkg::reg_idx_t         reg_idx;
    logic                      cfg_write;
    tbc_pkg::lane_ctrl_t       ctrl;
    logic                      accept;
    logic [tbc_pkg::LANES*tbc_pkg::PIX_W-1:0] lane_pixels;
    logic [tbc_pkg::FIRST_W-1:0] second_wide;

    // configuration port
    assign pready    = 1'b1;
    assign reg_idx   = tbc_pkg::reg_idx_t'(paddr[2]);
    assign cfg_write = psel & penable & pwrite;

    always_comb
    begin
        depth_mode_next   = depth_mode_reg;
        hires_select_next = hires_select_reg;
        if (cfg_write)
        begin
            unique case (reg_idx)
                tbc_pkg::REG_DEPTH_MODE:   depth_mode_next   = pwdata[tbc_pkg::CFG_W-1:0];
                tbc_pkg::REG_HIRES_SELECT: hires_select_next = pwdata[tbc_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            tbc_pkg::REG_DEPTH_MODE:
                prdata = tbc_pkg::PDATA_W'(depth_mode_reg);
            tbc_pkg::REG_HIRES_SELECT:
                prdata = tbc_pkg::PDATA_W'(hires_select_reg);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_mode_reg   <= tbc_pkg::DEPTH_RESET;
            hires_select_reg <= tbc_pkg::HIRES_RESET;
        end
        else
        begin
            depth_mode_reg   <= depth_mode_next;
            hires_select_reg <= hires_select_next;
        end
    end

    // lane control; hires only exists at two and four bpp
    always_comb
    begin
        ctrl.plane_mask = tbc_pkg::depth_plane_mask(depth_mode_reg);
        ctrl.hires      = ((depth_mode_reg == tbc_pkg::DEPTH_2BPP) ||
                           (depth_mode_reg == tbc_pkg::DEPTH_4BPP)) &&
                          ((hires_select_reg == tbc_pkg::HIRES_ODD) ||
                           (hires_select_reg == tbc_pkg::HIRES_EVEN));
        ctrl.odd        = (hires_select_reg == tbc_pkg::HIRES_ODD);
    end

    assign tile_stall  = chunk_valid & chunk_stall;
    assign accept      = tile_valid & ~tile_stall;
    assign second_wide = tbc_pkg::FIRST_W'(tile_row.plane_bytes_second);

    for (genvar k = 0; k < tbc_pkg::LANES; k++)
    begin : g_lane
        localparam logic [2:0] NORMAL_POS = 3'(k);
        localparam logic [2:0] HIRES_POS  = 3'(2 * (k % (tbc_pkg::LANES / 2)));

        logic [tbc_pkg::FIRST_W-1:0] src;
        logic [2:0]                  pos;

        // hires lanes in the upper half read the next tile's row
        if (k < tbc_pkg::LANES / 2)
        begin : g_lo
            assign src = tile_row.plane_bytes_first;
        end
        else
        begin : g_hi
            assign src = ctrl.hires ? second_wide : tile_row.plane_bytes_first;
        end

        assign pos = ctrl.hires ? (HIRES_POS | {2'b00, ctrl.odd}) : NORMAL_POS;

        tbc_lane u_lane
        (
            .planes     (src),
            .pos        (pos),
            .plane_mask (ctrl.plane_mask),
            .idx        (lane_pixels[k*tbc_pkg::PIX_W +: tbc_pkg::PIX_W])
        );
    end

    tbc_merge u_merge
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .lane_pixels (lane_pixels),
        .chunk_stall (chunk_stall),
        .chunk_valid (chunk_valid),
        .chunk_row   (chunk_row)
    );

endmodule

/* sv/tbc_checker.sv */
// port-level checks of the bitplane to chunky unit, bound to the top level
// depends on tbc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "tile_bitplane_to_chunky_unit_macros.svh"

module tbc_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          tile_stall,
    input logic          chunk_valid,
    input logic          chunk_stall,
    input tbc_pkg::out_t chunk_row
);

    // a held result stays put until it is taken
    `TBC_ASSERT_NEXT(a_hold, chunk_valid && chunk_stall, chunk_valid && $stable(chunk_row), "result changed while stalled")

    // the blank flag is only reported on the eighth row
    `TBC_ASSERT_NOW(a_flag_last, chunk_valid && !chunk_row.last_row, !chunk_row.tile_nonblank, "nonblank flag off the last row")

    // a nonzero last row always marks the tile nonblank
    `TBC_ASSERT_NOW(a_flag_seen, chunk_valid && chunk_row.last_row && (chunk_row.pixels != '0), chunk_row.tile_nonblank, "nonzero tile reported blank")

    // the input side only waits on a stalled full output register
    `TBC_ASSERT_NOW(a_stall_src, tile_stall, chunk_valid && chunk_stall, "input stalled without cause")

endmodule

bind tile_bitplane_to_chunky_unit tbc_checker u_tbc_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .tile_stall  (tile_stall),
    .chunk_valid (chunk_valid),
    .chunk_stall (chunk_stall),
    .chunk_row   (chunk_row)
);
